[rtl/assert_macros.svh]
// Assertion macros for the RTL of the bit error rate counter.
// Depends on nothing; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

[rtl/ber_pkg.sv]
// Types, constants and helper functions of the bit error rate counter.
// Depends on nothing; used by every module of the block but the RAM.
`default_nettype none

package ber_pkg;

   localparam int BER_MAX_REFERENCE = 2048;
   localparam int LEN_W             = 12;
   localparam int POS_W             = 11;
   localparam int BYTE_W            = 8;
   localparam int OUT_W             = 15;
   localparam int RATE_W            = 17;
   localparam int RATE_SHIFT        = 16;
   localparam int RATE_ONE          = 65536;
   localparam int BYTE_SHIFT        = 3;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_PACKET = 1'b1;

   typedef struct packed {
      logic              command;
      logic [POS_W-1:0]  position;
      logic [BYTE_W-1:0] data_byte;
      logic              last;
   } ber_req_type;

   typedef struct packed {
      logic [OUT_W-1:0]  error_bits;
      logic [OUT_W-1:0]  compared_bits;
      logic [RATE_W-1:0] error_rate;
      logic              empty_res;
   } ber_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } ber_state_type;

   function automatic logic [3:0] ber_popcount(input logic [BYTE_W-1:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

[rtl/ber_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module ber_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/ber_div.sv]
// Restoring divider, one quotient bit per cycle, for the error rate.
// Depends on ber_pkg.
`default_nettype none

module ber_div
   import ber_pkg::*;
#(
   parameter int DVD_W = 31,
   parameter int DVS_W = 15
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DVD_W-1:0]  dividend,
   input  wire logic [DVS_W-1:0]  divisor,
   output logic                   done,
   output logic      [RATE_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         dvd_in    = dividend;
         rem_in    = '0;
         dvs_in    = divisor;
      end else if (active_ff) begin
         dvd_in  = {dvd_ff[DVD_W-2:0], fits};
         rem_in  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == CNT_W'(DVD_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff[RATE_W-1:0];

endmodule

`default_nettype wire

[rtl/packet_bit_error_rate_counter.sv]
// Packet bit error rate counter: reference store, byte compare, rate divider.
// A reference write is taken while idle; a packet byte reads the store, then counts.
// Last byte: the result is loaded, divided by the bit-serial divider unless no
// bits were compared, then held until the receiver takes it.
// Synchronous reset clears counters and length; store contents stay undefined.
`default_nettype none
`include "assert_macros.svh"

module packet_bit_error_rate_counter
   import ber_pkg::*;
#(
   parameter int MAX_REFERENCE = BER_MAX_REFERENCE
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ber_req_type       req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ber_rsp_type            rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [LEN_W-1:0]  csr_wr_data
);

   localparam int ADDR_W = (MAX_REFERENCE > 1) ? $clog2(MAX_REFERENCE) : 1;
   localparam int CNT_W  = $clog2(MAX_REFERENCE + 1);
   localparam int ERR_W  = CNT_W + BYTE_SHIFT;
   localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int DVD_W  = ERR_W + RATE_SHIFT;

   ber_state_type     state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ERR_W-1:0]  err_ff, err_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              cmp_ff, cmp_in;
   logic              last_ff, last_in;
   ber_rsp_type       rsp_ff, rsp_in;

   logic              accept;
   logic              ram_we;
   logic [BYTE_W-1:0] ram_rd;
   logic              div_start;
   logic              div_done;
   logic [RATE_W-1:0] div_q;
   logic [ERR_W-1:0]  cbits;
   logic              in_len;

   assign accept = req_valid && !req_stall;
   assign cbits  = {cnt_ff, BYTE_SHIFT'(0)};
   assign in_len = (CMP_W'(idx_ff) < CMP_W'(len_ff)) && (idx_ff < CNT_W'(MAX_REFERENCE));
   assign ram_we = accept && (req_data.command == CMD_WRITE)
                   && (32'(req_data.position) < 32'(MAX_REFERENCE));

   ber_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_REFERENCE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_W'(req_data.position)),
      .wr_data (req_data.data_byte),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd)
   );

   ber_div #(
      .DVD_W (DVD_W),
      .DVS_W (ERR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({err_ff, RATE_SHIFT'(0)}),
      .divisor  (cbits),
      .done     (div_done),
      .quotient (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.command == CMD_PACKET)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = last_ff ? ST_LOAD : ST_IDLE;
         ST_LOAD: state_in = (cnt_ff == '0) ? ST_OUT : ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      len_in    = csr_wr_en ? csr_wr_data : len_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      byte_in   = byte_ff;
      cmp_in    = cmp_ff;
      last_in   = last_ff;
      rsp_in    = rsp_ff;
      div_start = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.command == CMD_PACKET)) begin
               byte_in = req_data.data_byte;
               last_in = req_data.last;
               cmp_in  = in_len;
               if (idx_ff < CNT_W'(MAX_REFERENCE)) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_READ: begin
            if (cmp_ff) begin
               err_in = err_ff + ERR_W'(ber_popcount(byte_ff ^ ram_rd));
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            rsp_in.error_bits    = OUT_W'(err_ff);
            rsp_in.compared_bits = OUT_W'(cbits);
            rsp_in.error_rate    = '0;
            rsp_in.empty_res     = (cnt_ff == '0);
            div_start            = (cnt_ff != '0);
            idx_in               = '0;
            cnt_in               = '0;
            err_in               = '0;
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_in.error_rate = div_q;
            end
         end
         ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         err_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
      end
      byte_ff <= byte_in;
      cmp_ff  <= cmp_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   `ASSERT_NEVER(a_err_le_bits, clock, reset, err_ff > cbits)
   `ASSERT_PROP(a_empty_zero, clock, reset, rsp_valid && rsp_data.empty_res |-> rsp_data.error_bits == '0 && rsp_data.compared_bits == '0 && rsp_data.error_rate == '0)
   `ASSERT_PROP(a_rate_max, clock, reset, rsp_valid && !rsp_data.empty_res |-> 32'(rsp_data.error_rate) <= RATE_ONE)
   `ASSERT_PROP(a_restart, clock, reset, rsp_valid && !rsp_stall |=> state_ff == ST_IDLE && idx_ff == '0 && err_ff == '0)

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for packet_bit_error_rate_counter: loads reference bytes,
// streams packets under several pacing modes and checks each report against a predictor.
// Depends on ber_pkg and the RTL top level only.

module tb;
   import ber_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int STORE_DEPTH    = BER_MAX_REFERENCE;
   localparam int BITS_PER_BYTE  = 8;
   localparam int SETTLE_CYCLES  = 64;
   localparam int TIMEOUT_CYCLES = 400000;

   typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_type;
   typedef enum int {FILL_MATCH, FILL_INVERT, FILL_FLIP, FILL_RANDOM, FILL_MIXED} fill_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   ber_req_type       req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   ber_rsp_type       rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [LEN_W-1:0]  csr_wr_data = '0;

   packet_bit_error_rate_counter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // predictor state
   logic [BYTE_W-1:0] golden_bytes [STORE_DEPTH];
   logic [LEN_W-1:0]  golden_length   = '0;
   int unsigned       golden_index    = 0;
   int unsigned       golden_errors   = 0;
   int unsigned       golden_compared = 0;

   // stimulus planning state
   bit [BYTE_W-1:0]   plan_ref     [STORE_DEPTH];
   bit                plan_written [STORE_DEPTH];
   int unsigned       plan_pos  = 0;
   int unsigned       plan_span = 0;

   ber_req_type       pending_requests [$];
   ber_rsp_type       expected_reports [$];

   int                sender_idle_pct    = 0;
   int                receiver_stall_pct = 0;
   bit                req_fired          = 1'b0;
   int                fault_count        = 0;
   int                request_count      = 0;
   int                report_count       = 0;
   int                length_writes      = 0;

   int unsigned       phase_lengths [9] = '{1, 7, 16, 300, 64, 2048, 0, 4095, 33};

   task automatic score_request(input ber_req_type r);
      int unsigned span;
      int unsigned cbits;
      ber_rsp_type rpt;
      if (r.command == CMD_WRITE) begin
         golden_bytes[r.position] = r.data_byte;
      end else begin
         span = (golden_length > STORE_DEPTH) ? STORE_DEPTH : golden_length;
         if (golden_index < span) begin
            golden_errors += $countones(r.data_byte ^ golden_bytes[golden_index]);
            golden_compared++;
         end
         if (golden_index < STORE_DEPTH) begin
            golden_index++;
         end
         if (r.last) begin
            cbits = golden_compared * BITS_PER_BYTE;
            rpt   = '0;
            if (cbits == 0) begin
               rpt.empty_res = 1'b1;
            end else begin
               rpt.error_bits    = OUT_W'(golden_errors);
               rpt.compared_bits = OUT_W'(cbits);
               rpt.error_rate    = RATE_W'((64'(golden_errors) << RATE_SHIFT) / cbits);
            end
            expected_reports.push_back(rpt);
            golden_index    = 0;
            golden_errors   = 0;
            golden_compared = 0;
         end
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      req_fired = !reset && req_valid && !req_stall;
      if (req_fired) begin
         score_request(req_data);
         pending_requests.delete(0);
         request_count++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_requests[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin : report_monitor
      ber_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected report: error_bits %0d, compared_bits %0d",
                   rsp_data.error_bits, rsp_data.compared_bits);
            fault_count++;
         end else begin
            want = expected_reports.pop_front();
            check_field("error_bits", 32'(want.error_bits), 32'(rsp_data.error_bits));
            check_field("compared_bits", 32'(want.compared_bits),
                        32'(rsp_data.compared_bits));
            check_field("error_rate", 32'(want.error_rate), 32'(rsp_data.error_rate));
            check_field("empty_res", 32'(want.empty_res), 32'(rsp_data.empty_res));
            report_count++;
         end
      end
   end

   task automatic add_request(input logic cmd, input logic [POS_W-1:0] pos,
                              input logic [BYTE_W-1:0] value, input logic last);
      ber_req_type r;
      r.command   = cmd;
      r.position  = pos;
      r.data_byte = value;
      r.last      = last;
      pending_requests.push_back(r);
      if (cmd == CMD_WRITE) begin
         plan_ref[pos]     = value;
         plan_written[pos] = 1'b1;
      end else if (last) begin
         plan_pos = 0;
      end else if (plan_pos < STORE_DEPTH) begin
         plan_pos++;
      end
   endtask

   task automatic add_packet_byte(input fill_type mode, input logic last);
      int unsigned       slot;
      fill_type          pick;
      logic [BYTE_W-1:0] ref_byte;
      logic [BYTE_W-1:0] value;
      slot = plan_pos;
      // load the reference entry first so that no unwritten entry is compared
      if (slot < plan_span && !plan_written[slot]) begin
         add_request(CMD_WRITE, POS_W'(slot), BYTE_W'($urandom), 1'($urandom));
      end
      pick     = (mode == FILL_MIXED) ? fill_type'($urandom_range(3)) : mode;
      ref_byte = (slot < STORE_DEPTH) ? plan_ref[slot] : '0;
      case (pick)
         FILL_MATCH:  value = ref_byte;
         FILL_INVERT: value = ~ref_byte;
         FILL_FLIP:   value = ref_byte ^ (8'h01 << $urandom_range(7));
         default:     value = BYTE_W'($urandom);
      endcase
      add_request(CMD_PACKET, POS_W'($urandom), value, last);
   endtask

   task automatic add_packet(input int unsigned bytes_in_packet, input fill_type mode);
      for (int unsigned i = 1; i < bytes_in_packet; i++) begin
         add_packet_byte(mode, 1'b0);
      end
      add_packet_byte(mode, 1'b1);
   endtask

   task automatic add_random_traffic(input int count);
      int target;
      int roll;
      int unsigned bytes_in_packet;
      target = pending_requests.size() + count;
      while (pending_requests.size() < target) begin
         roll = $urandom_range(99);
         if (roll < 12) begin
            add_request(CMD_WRITE, POS_W'($urandom), BYTE_W'($urandom), 1'($urandom));
         end else if (roll < 20) begin
            repeat ($urandom_range(1, 4)) add_packet_byte(FILL_MIXED, 1'b0);
         end else begin
            if (roll < 60) begin
               bytes_in_packet = $urandom_range(1, 8);
            end else if (roll < 92 || plan_span > 320) begin
               bytes_in_packet = $urandom_range(1, 40);
            end else begin
               bytes_in_packet = $urandom_range(plan_span + 3,
                                                (plan_span > 2) ? plan_span - 2 : 1);
            end
            add_packet(bytes_in_packet, FILL_MIXED);
         end
      end
      // may leave a packet open across the next length change
      repeat ($urandom_range(3)) add_packet_byte(FILL_MIXED, 1'b0);
   endtask

   task automatic drain_reports();
      while (pending_requests.size() != 0 || expected_reports.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_length(input int unsigned value);
      drain_reports();
      csr_wr_en   = 1'b1;
      csr_wr_data = LEN_W'(value);
      @(negedge clock);
      csr_wr_en     = 1'b0;
      golden_length = LEN_W'(value);
      plan_span     = (value > STORE_DEPTH) ? STORE_DEPTH : value;
      length_writes++;
   endtask

   task automatic set_pace(input pace_type pace);
      sender_idle_pct    = (pace == PACE_SENDER) ? 75 : (pace == PACE_BOTH) ? 11 : 0;
      receiver_stall_pct = (pace == PACE_RECEIVER) ? 75 : (pace == PACE_BOTH) ? 11 : 0;
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;

      set_pace(PACE_FREE);
      add_request(CMD_WRITE, '1, 8'hFF, 1'b1);
      add_request(CMD_WRITE, '0, 8'h00, 1'b0);
      add_packet(1, FILL_RANDOM);
      add_packet(3, FILL_RANDOM);
      program_length(3);
      add_packet(3, FILL_MATCH);
      add_packet(3, FILL_INVERT);
      add_packet(5, FILL_FLIP);
      add_packet_byte(FILL_MATCH, 1'b0);
      add_request(CMD_WRITE, POS_W'(1), 8'hA5, 1'b1);
      add_packet_byte(FILL_INVERT, 1'b1);

      for (int p = 0; p < 9; p++) begin
         program_length(phase_lengths[p]);
         set_pace(pace_type'(p % 4));
         add_random_traffic(110);
      end

      add_packet_byte(FILL_MIXED, 1'b1);

      drain_reports();
      $display("Covered %0d requests and %0d reports across %0d reference lengths,",
               request_count, report_count, length_writes);
      $display("under free-running, sender-idle, receiver-stall and mixed pacing.");
      if (fault_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
